// ===== sv/rlg_pkg.sv =====
package rlg_pkg;

   localparam int TS_W     = 32;
   localparam int PERIOD_W = 8;
   localparam int MS_W     = 16;
   localparam int CAP_W    = 4;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_REPORT_PERIOD   = 3'd0,
      REG_SILENCE_FALLBACK = 3'd1,
      REG_WEDGE_TIMEOUT   = 3'd2,
      REG_RESET_SPACING   = 3'd3,
      REG_RESET_ATTEMPT_CAP = 3'd4,
      REG_CALL_GAP        = 3'd5,
      REG_PAD_ABSENT      = 3'd6
   } reg_index_type;

   localparam logic [PERIOD_W-1:0] RST_REPORT_PERIOD    = 8'd10;
   localparam logic [MS_W-1:0]     RST_SILENCE_FALLBACK = 16'd250;
   localparam logic [MS_W-1:0]     RST_WEDGE_TIMEOUT    = 16'd3000;
   localparam logic [MS_W-1:0]     RST_RESET_SPACING    = 16'd10000;
   localparam logic [CAP_W-1:0]    RST_RESET_ATTEMPT_CAP = 4'd3;
   localparam logic [MS_W-1:0]     RST_CALL_GAP         = 16'd500;

   typedef struct packed {
      logic [PERIOD_W-1:0] report_period_ms;
      logic [MS_W-1:0]     silence_fallback_ms;
      logic [MS_W-1:0]     wedge_timeout_ms;
      logic [MS_W-1:0]     reset_spacing_ms;
      logic [CAP_W-1:0]    reset_attempt_cap;
      logic [MS_W-1:0]     call_gap_ms;
      logic                pad_absent;
   } cfg_type;

   typedef struct packed {
      logic read_now;
      logic reset_sensor;
   } result_type;

endpackage

// ===== sv/rlg_chan_if.sv =====
interface rlg_req_if;
   logic                       valid;
   logic                       ready;
   logic [rlg_pkg::TS_W-1:0]   now_ms;
   logic                       ready_level;

   modport source (output valid, output now_ms, output ready_level, input ready);
   modport sink   (input valid, input now_ms, input ready_level, output ready);
endinterface

interface rlg_rsp_if;
   logic valid;
   logic ready;
   logic read_now;
   logic reset_sensor;

   modport source (output valid, output read_now, output reset_sensor, input ready);
   modport sink   (input valid, input read_now, input reset_sensor, output ready);
endinterface

// ===== sv/rlg_csr.sv =====
module rlg_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [rlg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rlg_pkg::CSR_W-1:0]       csr_wdata,
   output rlg_pkg::cfg_type                cfg
);

   rlg_pkg::cfg_type cfg_ff;
   rlg_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            rlg_pkg::REG_REPORT_PERIOD:
               cfg_in.report_period_ms = csr_wdata[rlg_pkg::PERIOD_W-1:0];
            rlg_pkg::REG_SILENCE_FALLBACK:
               cfg_in.silence_fallback_ms = csr_wdata;
            rlg_pkg::REG_WEDGE_TIMEOUT:
               cfg_in.wedge_timeout_ms = csr_wdata;
            rlg_pkg::REG_RESET_SPACING:
               cfg_in.reset_spacing_ms = csr_wdata;
            rlg_pkg::REG_RESET_ATTEMPT_CAP:
               cfg_in.reset_attempt_cap = csr_wdata[rlg_pkg::CAP_W-1:0];
            rlg_pkg::REG_CALL_GAP:
               cfg_in.call_gap_ms = csr_wdata;
            rlg_pkg::REG_PAD_ABSENT:
               cfg_in.pad_absent = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.report_period_ms    <= rlg_pkg::RST_REPORT_PERIOD;
         cfg_ff.silence_fallback_ms <= rlg_pkg::RST_SILENCE_FALLBACK;
         cfg_ff.wedge_timeout_ms    <= rlg_pkg::RST_WEDGE_TIMEOUT;
         cfg_ff.reset_spacing_ms    <= rlg_pkg::RST_RESET_SPACING;
         cfg_ff.reset_attempt_cap   <= rlg_pkg::RST_RESET_ATTEMPT_CAP;
         cfg_ff.call_gap_ms         <= rlg_pkg::RST_CALL_GAP;
         cfg_ff.pad_absent          <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/rlg_engine.sv =====
module rlg_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [rlg_pkg::TS_W-1:0]     now_ms,
   input  logic                         ready_level,
   input  rlg_pkg::cfg_type             cfg,
   output rlg_pkg::result_type          result
);

   localparam int TS_W = rlg_pkg::TS_W;
   localparam int PW   = rlg_pkg::PERIOD_W;

   logic [TS_W-1:0]          edge_stamp_ff, edge_stamp_in;
   logic [TS_W-1:0]          read_stamp_ff, read_stamp_in;
   logic [TS_W-1:0]          reset_stamp_ff, reset_stamp_in;
   logic [TS_W-1:0]          call_stamp_ff;
   logic [rlg_pkg::CAP_W-1:0] attempt_ff, attempt_in, attempt_eff;
   logic                     prev_ready_ff, prev_ready_in;

   logic [TS_W-1:0] el_call, el_read, el_edge, el_reset;
   logic [TS_W-1:0] edge_base, edge_eff;
   logic [PW:0]     poll_period, double_period;
   logic [PW-1:0]   floor_period;
   logic            rise, want, do_read, do_reset, read_poll;

   always_comb begin
      poll_period   = {1'b0, cfg.report_period_ms} + (PW+1)'(1);
      double_period = {cfg.report_period_ms, 1'b0};
      floor_period  = (cfg.report_period_ms == '0) ? '0
                      : cfg.report_period_ms - PW'(1);

      el_call   = now_ms - call_stamp_ff;
      edge_base = (el_call > TS_W'(cfg.call_gap_ms)) ? now_ms : edge_stamp_ff;
      el_read   = now_ms - read_stamp_ff;
      read_poll = el_read >= TS_W'(poll_period);

      rise        = ready_level & ~prev_ready_ff;
      edge_eff    = rise ? now_ms : edge_base;
      attempt_eff = rise ? '0 : attempt_ff;
      el_edge     = now_ms - edge_eff;
      el_reset    = now_ms - reset_stamp_ff;

      if (ready_level) begin
         want = rise | (el_read >= TS_W'(double_period));
      end else begin
         want = (el_edge > TS_W'(cfg.silence_fallback_ms)) & read_poll;
      end

      if (cfg.pad_absent) begin
         do_read  = read_poll;
         do_reset = 1'b0;
      end else begin
         do_read  = want & (el_read >= TS_W'(floor_period));
         do_reset = ~do_read
                    & (el_edge > TS_W'(cfg.wedge_timeout_ms))
                    & (attempt_eff < cfg.reset_attempt_cap)
                    & (el_reset > TS_W'(cfg.reset_spacing_ms));
      end

      read_stamp_in  = do_read ? now_ms : read_stamp_ff;
      reset_stamp_in = do_reset ? now_ms : reset_stamp_ff;
      if (cfg.pad_absent) begin
         edge_stamp_in = edge_base;
         attempt_in    = attempt_ff;
         prev_ready_in = prev_ready_ff;
      end else begin
         edge_stamp_in = do_reset ? now_ms : edge_eff;
         attempt_in    = do_reset ? attempt_eff + rlg_pkg::CAP_W'(1) : attempt_eff;
         prev_ready_in = ready_level;
      end

      result.read_now     = do_read;
      result.reset_sensor = do_reset;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_stamp_ff  <= '0;
         read_stamp_ff  <= '0;
         reset_stamp_ff <= '0;
         call_stamp_ff  <= '0;
         attempt_ff     <= '0;
         prev_ready_ff  <= 1'b0;
      end else if (step) begin
         edge_stamp_ff  <= edge_stamp_in;
         read_stamp_ff  <= read_stamp_in;
         reset_stamp_ff <= reset_stamp_in;
         call_stamp_ff  <= now_ms;
         attempt_ff     <= attempt_in;
         prev_ready_ff  <= prev_ready_in;
      end
   end

endmodule

// ===== sv/ready_line_read_gate_with_recovery.sv =====
// Ready-line read gate with wedge recovery. Each request transaction carries a
// wrapping millisecond timestamp and the sampled ready line; each one yields
// exactly one response transaction telling whether to read a sensor report now
// (read_now) or to pulse the sensor reset and reinitialize it (reset_sensor),
// never both. Reads follow rising edges, a line held high for two report
// periods, or timed polling after silence, floored at one report period less
// one ms; with pad_absent set the block only polls on a timer. It takes one
// transaction per clock cycle unless the response side stalls; a request passes
// the input register, then the combinational decision and state update, then
// the result register. The user must write registers through the csr port only
// while idle; the block itself does not enforce this.
module ready_line_read_gate_with_recovery (
   input  logic                           clock,
   input  logic                           reset,
   rlg_req_if.sink                        req_bus,
   rlg_rsp_if.source                      rsp_bus,
   input  logic                           csr_we,
   input  logic [rlg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rlg_pkg::CSR_W-1:0]      csr_wdata
);

   rlg_pkg::cfg_type    cfg;
   rlg_pkg::result_type result;

   logic                     in_valid_ff;
   logic [rlg_pkg::TS_W-1:0] in_now_ff;
   logic                     in_level_ff;
   logic                     out_valid_ff;
   rlg_pkg::result_type      out_ff;
   logic                     advance;

   assign advance       = in_valid_ff & (~out_valid_ff | rsp_bus.ready);
   assign req_bus.ready = ~in_valid_ff | advance;

   rlg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rlg_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .now_ms      (in_now_ff),
      .ready_level (in_level_ff),
      .cfg         (cfg),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_now_ff   <= req_bus.now_ms;
         in_level_ff <= req_bus.ready_level;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.read_now     = out_ff.read_now;
   assign rsp_bus.reset_sensor = out_ff.reset_sensor;

endmodule

// ===== tb/rlg_decision_checker.sv =====
`timescale 1ns / 1ps
module rlg_decision_checker (
   input  logic                          clock,
   input  logic                          reset,
   rlg_req_if                            req_mon,
   rlg_rsp_if                            rsp_mon,
   input  logic                          csr_we,
   input  logic [rlg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rlg_pkg::CSR_W-1:0]     csr_wdata,
   output int                            fail_count,
   output int                            outstanding
);
   import rlg_pkg::*;

   cfg_type          cfg;
   logic [TS_W-1:0]  edge_stamp;
   logic [TS_W-1:0]  read_stamp;
   logic [TS_W-1:0]  reset_stamp;
   logic [TS_W-1:0]  call_stamp;
   logic [CAP_W-1:0] attempts;
   logic             prev_level;
   result_type       pending_decisions[$];
   int               mismatches = 0;

   function automatic result_type decide_poll(input logic [TS_W-1:0] t, input logic level);
      result_type      d;
      logic [TS_W-1:0] poll_period;
      logic [TS_W-1:0] hold_period;
      logic [TS_W-1:0] floor_period;
      logic [TS_W-1:0] since_read;
      logic            rise;
      logic            want;
      d = '0;
      want = 1'b0;
      poll_period = TS_W'(cfg.report_period_ms) + 32'd1;
      hold_period = TS_W'(cfg.report_period_ms) << 1;
      floor_period = (cfg.report_period_ms == '0) ? '0 : TS_W'(cfg.report_period_ms) - 32'd1;
      if (t - call_stamp > TS_W'(cfg.call_gap_ms)) begin
         edge_stamp = t;
      end
      call_stamp = t;
      if (cfg.pad_absent) begin
         if (t - read_stamp >= poll_period) begin
            read_stamp = t;
            d.read_now = 1'b1;
         end
         return d;
      end
      rise = level && !prev_level;
      prev_level = level;
      if (rise) begin
         edge_stamp = t;
         attempts = '0;
      end
      since_read = t - read_stamp;
      if (level) begin
         want = rise || (since_read >= hold_period);
      end else if (t - edge_stamp > TS_W'(cfg.silence_fallback_ms)) begin
         want = since_read >= poll_period;
      end
      if (want && since_read >= floor_period) begin
         read_stamp = t;
         d.read_now = 1'b1;
         return d;
      end
      if (t - edge_stamp > TS_W'(cfg.wedge_timeout_ms) && attempts < cfg.reset_attempt_cap &&
          t - reset_stamp > TS_W'(cfg.reset_spacing_ms)) begin
         reset_stamp = t;
         edge_stamp = t;
         attempts = attempts + 1'b1;
         d.reset_sensor = 1'b1;
      end
      return d;
   endfunction

   always @(posedge clock) begin
      result_type exp_d;
      if (reset) begin
         cfg.report_period_ms = RST_REPORT_PERIOD;
         cfg.silence_fallback_ms = RST_SILENCE_FALLBACK;
         cfg.wedge_timeout_ms = RST_WEDGE_TIMEOUT;
         cfg.reset_spacing_ms = RST_RESET_SPACING;
         cfg.reset_attempt_cap = RST_RESET_ATTEMPT_CAP;
         cfg.call_gap_ms = RST_CALL_GAP;
         cfg.pad_absent = 1'b0;
         edge_stamp = '0;
         read_stamp = '0;
         reset_stamp = '0;
         call_stamp = '0;
         attempts = '0;
         prev_level = 1'b0;
         pending_decisions.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_REPORT_PERIOD:     cfg.report_period_ms = csr_wdata[PERIOD_W-1:0];
               REG_SILENCE_FALLBACK:  cfg.silence_fallback_ms = csr_wdata[MS_W-1:0];
               REG_WEDGE_TIMEOUT:     cfg.wedge_timeout_ms = csr_wdata[MS_W-1:0];
               REG_RESET_SPACING:     cfg.reset_spacing_ms = csr_wdata[MS_W-1:0];
               REG_RESET_ATTEMPT_CAP: cfg.reset_attempt_cap = csr_wdata[CAP_W-1:0];
               REG_CALL_GAP:          cfg.call_gap_ms = csr_wdata[MS_W-1:0];
               REG_PAD_ABSENT:        cfg.pad_absent = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_decisions.size() == 0) begin
               $error("response transaction with no decision pending");
               mismatches++;
            end else begin
               exp_d = pending_decisions.pop_front();
               if (rsp_mon.read_now !== exp_d.read_now) begin
                  $error("read_now: expected %0b, actual %0b", exp_d.read_now,
                         rsp_mon.read_now);
                  mismatches++;
               end
               if (rsp_mon.reset_sensor !== exp_d.reset_sensor) begin
                  $error("reset_sensor: expected %0b, actual %0b", exp_d.reset_sensor,
                         rsp_mon.reset_sensor);
                  mismatches++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            pending_decisions.push_back(decide_poll(req_mon.now_ms, req_mon.ready_level));
         end
      end
      outstanding <= pending_decisions.size();
      fail_count <= mismatches;
   end
endmodule

// ===== tb/ready_line_read_gate_with_recovery_test.sv =====
`timescale 1ns / 1ps
module ready_line_read_gate_with_recovery_test;
   import rlg_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 3'd7;
   localparam int RUN_LIMIT_NS = 5_000_000;

   typedef enum int {
      LINE_PULSED,
      LINE_STUCK_LOW,
      LINE_STUCK_HIGH,
      LINE_NOISE
   } line_mode_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   int                   fail_count;
   int                   outstanding;
   int                   tx_idle_pct;
   int                   rx_idle_pct;
   logic [TS_W-1:0]      stamp;
   cfg_type              cfg;

   rlg_req_if req_bus ();
   rlg_rsp_if rsp_bus ();

   ready_line_read_gate_with_recovery dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rlg_decision_checker decision_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   initial begin
      #RUN_LIMIT_NS;
      $display("TEST FAILED");
      $finish;
   end

   function automatic cfg_type make_cfg(input int p, input int fb, input int wedge,
                                        input int spacing, input int cap, input int gap,
                                        input int absent);
      cfg_type c;
      c.report_period_ms = PERIOD_W'(p);
      c.silence_fallback_ms = MS_W'(fb);
      c.wedge_timeout_ms = MS_W'(wedge);
      c.reset_spacing_ms = MS_W'(spacing);
      c.reset_attempt_cap = CAP_W'(cap);
      c.call_gap_ms = MS_W'(gap);
      c.pad_absent = absent[0];
      return c;
   endfunction

   task automatic send_poll(input logic [TS_W-1:0] t, input logic level);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.now_ms <= t;
      req_bus.ready_level <= level;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // upper data bits carry junk to exercise width masking
   task automatic program_regs(input cfg_type c);
      logic [CSR_IDX_W-1:0] idx[8];
      logic [CSR_W-1:0]     val[8];
      idx[0] = REG_REPORT_PERIOD;
      val[0] = {8'($urandom), c.report_period_ms};
      idx[1] = REG_SILENCE_FALLBACK;
      val[1] = c.silence_fallback_ms;
      idx[2] = REG_WEDGE_TIMEOUT;
      val[2] = c.wedge_timeout_ms;
      idx[3] = REG_RESET_SPACING;
      val[3] = c.reset_spacing_ms;
      idx[4] = REG_RESET_ATTEMPT_CAP;
      val[4] = {12'($urandom), c.reset_attempt_cap};
      idx[5] = REG_CALL_GAP;
      val[5] = c.call_gap_ms;
      idx[6] = REG_PAD_ABSENT;
      val[6] = {15'($urandom), c.pad_absent};
      idx[7] = REG_UNMAPPED;
      val[7] = 16'($urandom);
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      repeat (2) @(posedge clock);
   endtask

   task automatic run_random(input int count);
      line_mode_type mode;
      int            left;
      int            roll;
      int            beat;
      int            pulse_len;
      int            step_max;
      logic          level;
      mode = LINE_PULSED;
      left = 0;
      beat = 0;
      pulse_len = 3;
      level = 1'b0;
      step_max = 2 * int'(cfg.report_period_ms) + 3;
      for (int k = 0; k < count; k++) begin
         if (left == 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) mode = LINE_PULSED;
            else if (roll < 65) mode = LINE_STUCK_LOW;
            else if (roll < 80) mode = LINE_STUCK_HIGH;
            else mode = LINE_NOISE;
            left = $urandom_range(6, 40);
            pulse_len = $urandom_range(2, 6);
         end
         left--;
         beat++;
         roll = $urandom_range(0, 99);
         if (roll < 2) begin
            stamp = $urandom;
         end else if (roll < 6) begin
            stamp = stamp + cfg.call_gap_ms + $urandom_range(0, 3);
         end else begin
            stamp = stamp + $urandom_range(0, step_max);
         end
         case (mode)
            LINE_PULSED:     level = (beat % pulse_len) == 0;
            LINE_STUCK_LOW:  level = 1'b0;
            LINE_STUCK_HIGH: level = 1'b1;
            default:         level = $urandom_range(0, 1);
         endcase
         send_poll(stamp, level);
         if ($urandom_range(0, 49) == 0) drain();
      end
   endtask

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.now_ms <= '0;
      req_bus.ready_level <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      reset <= 1'b1;
      tx_idle_pct = 38;
      rx_idle_pct = 50;
      stamp = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_poll(32'd0, 1'b0);
      send_poll(32'd5, 1'b1);
      send_poll(32'd30, 1'b1);
      send_poll(32'd400, 1'b0);
      send_poll(32'hFFFF_FFFF, 1'b0);
      drain();

      cfg = make_cfg(4, 8, 12, 6, 2, 100, 0);
      program_regs(cfg);
      send_poll(32'd0, 1'b0);
      send_poll(32'd1, 1'b1);
      send_poll(32'd2, 1'b1);
      send_poll(32'd9, 1'b1);
      send_poll(32'd10, 1'b0);
      send_poll(32'd20, 1'b0);
      send_poll(32'd22, 1'b0);
      send_poll(32'd36, 1'b0);
      send_poll(32'd37, 1'b0);
      send_poll(32'd60, 1'b0);
      send_poll(32'd61, 1'b0);
      send_poll(32'd62, 1'b1);
      send_poll(32'd300, 1'b0);
      send_poll(32'hFFFF_FFF0, 1'b1);
      send_poll(32'hFFFF_FFFF, 1'b1);
      send_poll(32'd3, 1'b1);
      drain();

      // zero report period: no read floor
      cfg = make_cfg(0, 0, 0, 0, 15, 65535, 0);
      program_regs(cfg);
      send_poll(32'd100, 1'b1);
      send_poll(32'd100, 1'b1);
      send_poll(32'd101, 1'b0);
      send_poll(32'd102, 1'b0);
      drain();

      cfg = make_cfg(255, 65535, 65535, 65535, 0, 0, 1);
      program_regs(cfg);
      send_poll(32'd10, 1'b1);
      send_poll(32'd300, 1'b0);
      send_poll(32'd301, 1'b1);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase / 2)
            0: begin
               tx_idle_pct = 38;
               rx_idle_pct = 50;
            end
            1: begin
               tx_idle_pct = 50;
               rx_idle_pct = 38;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         case (phase)
            0: cfg = make_cfg(4, 20, 40, 60, 3, 200, 0);
            1: cfg = make_cfg(1, 0, 0, 0, 15, 0, 0);
            2: cfg = make_cfg(0, 5, 25, 10, 1, 65535, 0);
            3: cfg = make_cfg(255, 65535, 65535, 65535, 0, 65535, 0);
            4: cfg = make_cfg($urandom_range(0, 255), $urandom, $urandom, $urandom,
                              $urandom, $urandom_range(0, 600), 1);
            default: cfg = make_cfg($urandom_range(1, 20), $urandom_range(0, 60),
                                    $urandom_range(0, 150), $urandom_range(0, 200),
                                    $urandom_range(0, 15), $urandom_range(0, 300), 0);
         endcase
         program_regs(cfg);
         case ($urandom_range(0, 2))
            0: stamp = '0;
            1: stamp = 32'hFFFF_FF00 + $urandom_range(0, 255);
            default: stamp = $urandom;
         endcase
         run_random(100);
         drain();
      end

      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
